// ----- hw/rtl/dual_stepper_half_step_slew_core_macros.svh -----
// ----------------------------------------------------------------------------
// Dual stepper slew core: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_STEPPER_HALF_STEP_SLEW_CORE_MACROS_SVH
`define DUAL_STEPPER_HALF_STEP_SLEW_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual stepper slew package
// Types, codes, pin maps and constants shared by the slew core modules.
// ----------------------------------------------------------------------------
package dss_pkg;

	typedef enum logic [2:0] {
		ACT_AZ_STEP  = 3'd0,
		ACT_AZ_STOP  = 3'd1,
		ACT_CAM_MOVE = 3'd2,
		ACT_CAM_STOP = 3'd3,
		ACT_TICK     = 3'd4
	} action_t;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_AZ_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_SPD      = 1'b1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [14:0] AZ_TOL_RST  = 15'd50;
	localparam logic [15:0] CAM_SPD_RST = 16'd2560;

	localparam logic [14:0] CAM_MAX = 15'd18000;

	// Remaining camera travel is kept as product >> 8, so one step is 100 units.
	localparam int unsigned REMAIN_W = 23;
	localparam logic [REMAIN_W-1:0] REMAIN_STEP  = 23'd100;
	localparam logic [REMAIN_W-1:0] REMAIN_FINAL = 23'd200;

	localparam logic [7:0] NIBBLE_HI = 8'hF0;
	localparam logic [7:0] NIBBLE_LO = 8'h0F;

	localparam logic [7:0] AZ_MAP [8] = '{
		8'h02, 8'h06, 8'h04, 8'h05, 8'h01, 8'h09, 8'h08, 8'h0A
	};
	localparam logic [7:0] CAM_MAP [8] = '{
		8'h40, 8'h60, 8'h20, 8'hA0, 8'h80, 8'h90, 8'h10, 8'h50
	};

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] target_angle;
		logic [15:0] current_angle;
	} item_t;

	typedef struct packed {
		logic [7:0]  coil_byte;
		logic        az_done;
		logic        cam_busy;
		logic [14:0] cam_position;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]          az_phase;
		logic [2:0]          cam_phase;
		logic [7:0]          coil;
		logic [14:0]         cam_angle;
		logic [14:0]         cam_target;
		logic [REMAIN_W-1:0] cam_remain;
		logic                cam_dir;
	} state_t;

	typedef struct packed {
		logic [14:0] az_tolerance;
		logic [15:0] cam_steps_per_degree;
	} cfg_t;

	typedef struct packed {
		logic can_load;
		logic out_valid;
		logic pend_valid;
	} buf_stat_t;

endpackage

// ----- hw/rtl/dss_req_if.sv -----
// ----------------------------------------------------------------------------
// Dual stepper slew request channel
// Valid/ready channel carrying one motor command or tick.
// ----------------------------------------------------------------------------
interface dss_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] target_angle;
	logic [15:0] current_angle;

	modport source (output valid, action, target_angle, current_angle, input ready);
	modport sink (input valid, action, target_angle, current_angle, output ready);
endinterface

// ----- hw/rtl/dss_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Dual stepper slew response channel
// Valid/ready channel carrying one coil byte with status.
// ----------------------------------------------------------------------------
interface dss_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  coil_byte;
	logic        az_done;
	logic        cam_busy;
	logic [14:0] cam_position;
	logic        last;

	modport source (output valid, coil_byte, az_done, cam_busy, cam_position, last,
		input ready);
	modport sink (input valid, coil_byte, az_done, cam_busy, cam_position, last,
		output ready);
endinterface

// ----- hw/rtl/dss_step.sv -----
// ----------------------------------------------------------------------------
// Dual stepper slew step logic
// Combinational next state and result words for one command.
// ----------------------------------------------------------------------------
module dss_step
	import dss_pkg::*;
(
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t first,
	output result_t second,
	output logic    two
);

	localparam logic signed [17:0] WRAP_HALF  = 18'sd18000;
	localparam logic signed [17:0] WRAP_1HALF = 18'sd54000;
	localparam logic signed [17:0] TURN_1     = 18'sd36000;
	localparam logic signed [17:0] TURN_2     = 18'sd72000;

	logic signed [17:0]  az_raw;
	logic signed [17:0]  az_diff;
	logic [17:0]         az_abs;
	logic [14:0]         az_mag;
	logic                az_in_tol;
	logic [14:0]         cam_tgt;
	logic signed [15:0]  cam_diff;
	logic [15:0]         cam_abs;
	logic [14:0]         cam_mag;
	logic [30:0]         cam_prod;
	logic [REMAIN_W-1:0] cam_steps;

	// Azimuth error, wrapped into one half turn either side.
	always_comb begin
		az_raw = $signed({2'b00, item.target_angle}) - $signed({2'b00, item.current_angle});
		if (az_raw > WRAP_1HALF) begin
			az_diff = az_raw - TURN_2;
		end else if (az_raw > WRAP_HALF) begin
			az_diff = az_raw - TURN_1;
		end else if (az_raw < -WRAP_1HALF) begin
			az_diff = az_raw + TURN_2;
		end else if (az_raw < -WRAP_HALF) begin
			az_diff = az_raw + TURN_1;
		end else begin
			az_diff = az_raw;
		end
		az_abs    = az_diff[17] ? 18'(-az_diff) : 18'(az_diff);
		az_mag    = az_abs[14:0];
		az_in_tol = az_mag <= cfg.az_tolerance;
	end

	// Camera travel in units of steps times 100.
	always_comb begin
		cam_tgt   = (item.target_angle > {1'b0, CAM_MAX}) ? CAM_MAX : item.target_angle[14:0];
		cam_diff  = $signed({1'b0, cam_tgt}) - $signed({1'b0, st.cam_angle});
		cam_abs   = cam_diff[15] ? 16'(-cam_diff) : 16'(cam_diff);
		cam_mag   = cam_abs[14:0];
		cam_prod  = cam_mag * cfg.cam_steps_per_degree;
		cam_steps = cam_prod[30:8];
	end

	always_comb begin
		logic    busy;
		logic    done;
		result_t mid;

		nxt  = st;
		done = 1'b0;
		two  = 1'b0;
		busy = st.cam_remain >= REMAIN_STEP;
		mid  = '0;

		case (action_t'(item.action))
			ACT_AZ_STEP: begin
				if (az_in_tol) begin
					nxt.coil = st.coil & NIBBLE_HI;
					done     = 1'b1;
				end else begin
					nxt.az_phase = (az_diff > 18'sd0) ? st.az_phase + 3'd1 : st.az_phase + 3'd7;
					nxt.coil     = AZ_MAP[nxt.az_phase] | CAM_MAP[st.cam_phase];
				end
			end
			ACT_AZ_STOP: begin
				nxt.coil = st.coil & NIBBLE_HI;
			end
			ACT_CAM_MOVE: begin
				if (!busy && cam_steps >= REMAIN_STEP) begin
					nxt.cam_remain = cam_steps;
					nxt.cam_target = cam_tgt;
					nxt.cam_dir    = !cam_diff[15] && (cam_diff != 16'sd0);
				end
			end
			ACT_CAM_STOP: begin
				nxt.coil = st.coil & NIBBLE_LO;
			end
			ACT_TICK: begin
				if (busy) begin
					nxt.cam_phase = st.cam_dir ? st.cam_phase + 3'd1 : st.cam_phase + 3'd7;
					nxt.coil      = AZ_MAP[st.az_phase] | CAM_MAP[nxt.cam_phase];
					if (st.cam_remain < REMAIN_FINAL) begin
						// Final step: report the stepped byte, then park the camera coils.
						two            = 1'b1;
						mid            = '{coil_byte: nxt.coil, az_done: 1'b0, cam_busy: 1'b1,
							cam_position: st.cam_angle, last: 1'b0};
						nxt.cam_remain = '0;
						nxt.cam_angle  = st.cam_target;
						nxt.coil       = nxt.coil & NIBBLE_LO;
					end else begin
						nxt.cam_remain = st.cam_remain - REMAIN_STEP;
					end
				end
			end
			default: begin
			end
		endcase

		second = '{coil_byte: nxt.coil, az_done: done,
			cam_busy: nxt.cam_remain >= REMAIN_STEP, cam_position: nxt.cam_angle, last: 1'b1};
		first  = two ? mid : second;
	end

endmodule

// ----- hw/rtl/dss_out_buf.sv -----
// ----------------------------------------------------------------------------
// Dual stepper slew output buffer
// Result register plus one pending word for commands that give two results.
// ----------------------------------------------------------------------------
module dss_out_buf
	import dss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  result_t      first,
	input  result_t      second,
	input  logic         two,
	output buf_stat_t    stat,
	dss_rsp_if.source    rsp
);

	result_t out_q;
	result_t pend_q;
	logic    out_valid_q;
	logic    pend_valid_q;
	logic    take;

	assign take = out_valid_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= two;
		end else if (take) begin
			if (pend_valid_q) begin
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= first;
			pend_q <= second;
		end else if (take && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign stat.can_load   = !pend_valid_q && (!out_valid_q || rsp.ready);
	assign stat.out_valid  = out_valid_q;
	assign stat.pend_valid = pend_valid_q;

	assign rsp.valid        = out_valid_q;
	assign rsp.coil_byte    = out_q.coil_byte;
	assign rsp.az_done      = out_q.az_done;
	assign rsp.cam_busy     = out_q.cam_busy;
	assign rsp.cam_position = out_q.cam_position;
	assign rsp.last         = out_q.last;

endmodule

// ----- hw/rtl/dual_stepper_half_step_slew_core.sv -----
// ----------------------------------------------------------------------------
// Dual stepper half-step slew core
// Sequences an azimuth and a camera half-step stepper sharing one coil byte.
// ----------------------------------------------------------------------------
//
// Channel   Role     Word
// req       sink     action, target_angle, current_angle
// rsp       source   coil_byte, az_done, cam_busy, cam_position, last
// cfg       write    cfg_wr_en, cfg_index, cfg_data
//
// A command is registered on acceptance and evaluated once the output buffer can
// take its result, which is then registered there; a new command can enter every
// cycle while the output buffer can take results. The final tick of a camera move
// yields two words and holds the command register while the second word drains from
// the output stage. Reset clears both motor phases, the coils, the camera position
// and its pending travel, and loads the register defaults. A stalled rsp holds the
// output words; req keeps accepting until the input register is full behind them.
//
module dual_stepper_half_step_slew_core
	import dss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	dss_req_if.sink               req,
	dss_rsp_if.source             rsp,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers. Writes must only arrive while the core is idle; the core does not enforce this.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.az_tolerance         <= AZ_TOL_RST;
			cfg_q.cam_steps_per_degree <= CAM_SPD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_AZ_TOLERANCE: cfg_q.az_tolerance         <= cfg_data[14:0];
				CFG_CAM_SPD:      cfg_q.cam_steps_per_degree <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register: the command being evaluated this cycle.
	item_t     item_s1;
	logic      valid_s1;
	logic      fire_s1;
	logic      req_take;
	buf_stat_t buf_stat;

	assign fire_s1   = valid_s1 && buf_stat.can_load;
	assign req.ready = !valid_s1 || fire_s1;
	assign req_take  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1 <= '{action: req.action, target_angle: req.target_angle,
				current_angle: req.current_angle};
		end
	end

	// Motor state. It advances only when a command is evaluated, so every command
	// sees the state its predecessor left behind.
	state_t  st_q;
	state_t  st_nxt;
	result_t res_first;
	result_t res_second;
	logic    res_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire_s1) begin
			st_q <= st_nxt;
		end
	end

	dss_step u_step (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg_q),
		.nxt    (st_nxt),
		.first  (res_first),
		.second (res_second),
		.two    (res_two)
	);

	dss_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire_s1),
		.first  (res_first),
		.second (res_second),
		.two    (res_two),
		.stat   (buf_stat),
		.rsp    (rsp)
	);

`include "dual_stepper_half_step_slew_core_macros.svh"

	// A queued second word always sits behind a valid output word.
	`DSS_ASSERT_SAME(a_pend_behind_out, buf_stat.pend_valid, buf_stat.out_valid, "pending word without output word")
	// No command is evaluated while a second word still waits.
	`DSS_ASSERT_SAME(a_no_fire_on_pend, buf_stat.pend_valid, !fire_s1, "command evaluated over a pending word")
	// Pending camera travel is either none or at least one whole step.
	`DSS_ASSERT_SAME(a_remain_whole, st_q.cam_remain != '0, st_q.cam_remain >= REMAIN_STEP, "partial camera step pending")
	// A two-word result always leaves the camera idle.
	`DSS_ASSERT_NEXT(a_final_idle, fire_s1 && res_two, st_q.cam_remain == '0, "camera still busy after final step")

endmodule

// ----- verif/tb_dual_stepper_half_step_slew_core.sv -----
// ----------------------------------------------------------------------------
// Dual stepper half-step slew core testbench
// Drives motor commands and ticks into the slew core under random back-pressure,
// predicts every coil word from a behavioral copy of both motors, and compares
// each returned word field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_dual_stepper_half_step_slew_core
	import dss_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_TURN      = 18000;
	localparam int FULL_TURN      = 36000;
	localparam int Q88_HUNDREDTH  = 25600;
	localparam int REPORT_MAX     = 10;
	localparam int QUIET_LIMIT    = 3000;
	localparam int IDLE_PAUSE     = 4;
	localparam int TAIL_CYCLES    = 8;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int NUM_PHASES     = 6;
	localparam int PER_PHASE      = 215;

	// Behavioral copy of both motors plus the queue of words still owed by the core.
	class coil_scoreboard;
		bit [2:0]  az_phase;
		bit [2:0]  cam_phase;
		bit [7:0]  coils;
		bit [14:0] cam_angle;
		bit [14:0] cam_goal;
		bit [15:0] steps_left;
		bit        cam_up;
		bit [14:0] tol;
		bit [15:0] spd;
		result_t   words_due[$];
		int        failures;

		function new();
			az_phase   = '0;
			cam_phase  = '0;
			coils      = '0;
			cam_angle  = '0;
			cam_goal   = '0;
			steps_left = '0;
			cam_up     = 1'b0;
			tol        = AZ_TOL_RST;
			spd        = CAM_SPD_RST;
			failures   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_AZ_TOLERANCE)
				tol = val[14:0];
			else
				spd = val;
		endfunction

		// Half-steps that a camera move toward this target would take from here.
		function int unsigned steps_for(logic [15:0] target);
			int unsigned t;
			int unsigned mag;
			t = (target > CAM_MAX) ? CAM_MAX : target;
			mag = (t > cam_angle) ? t - cam_angle : cam_angle - t;
			return (mag * spd) / Q88_HUNDREDTH;
		endfunction

		function void energize();
			coils = AZ_MAP[az_phase] | CAM_MAP[cam_phase];
		endfunction

		function void owe_word(bit done, bit fin);
			result_t w;
			w.coil_byte    = coils;
			w.az_done      = done;
			w.cam_busy     = (steps_left != 0);
			w.cam_position = cam_angle;
			w.last         = fin;
			words_due.push_back(w);
		endfunction

		function void accept_command(item_t c);
			int          diff;
			int unsigned mag;
			int unsigned t;
			int unsigned n;
			case (c.action)
				ACT_AZ_STEP: begin
					diff = int'(c.target_angle) - int'(c.current_angle);
					while (diff > HALF_TURN)
						diff -= FULL_TURN;
					while (diff < -HALF_TURN)
						diff += FULL_TURN;
					mag = (diff < 0) ? -diff : diff;
					if (mag <= tol) begin
						coils &= NIBBLE_HI;
						owe_word(1'b1, 1'b1);
						return;
					end
					az_phase = (diff > 0) ? az_phase + 3'd1 : az_phase - 3'd1;
					energize();
				end
				ACT_AZ_STOP: begin
					coils &= NIBBLE_HI;
				end
				ACT_CAM_MOVE: begin
					if (steps_left == 0) begin
						t = (c.target_angle > CAM_MAX) ? CAM_MAX : c.target_angle;
						n = steps_for(c.target_angle);
						if (n != 0) begin
							steps_left = n[15:0];
							cam_up     = (t > cam_angle);
							cam_goal   = t[14:0];
						end
					end
				end
				ACT_CAM_STOP: begin
					coils &= NIBBLE_LO;
				end
				ACT_TICK: begin
					if (steps_left != 0) begin
						cam_phase = cam_up ? cam_phase + 3'd1 : cam_phase - 3'd1;
						energize();
						if (steps_left == 1) begin
							// The final step owes the stepped word and then the
							// word with the camera coils released.
							owe_word(1'b0, 1'b0);
							steps_left = '0;
							cam_angle  = cam_goal;
							coils &= NIBBLE_LO;
							owe_word(1'b0, 1'b1);
							return;
						end
						steps_left -= 16'd1;
					end
				end
				default: begin
				end
			endcase
			owe_word(1'b0, 1'b1);
		endfunction

		function void show(string tag, result_t w);
			$display("  %s coil %02h done %0b busy %0b pos %0d last %0b", tag,
				w.coil_byte, w.az_done, w.cam_busy, w.cam_position, w.last);
		endfunction

		function void compare_word(result_t got);
			result_t due;
			if (words_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX) begin
					$display("word arrived with nothing outstanding");
					show("got     ", got);
				end
				return;
			end
			due = words_due.pop_front();
			if (got.coil_byte !== due.coil_byte || got.az_done !== due.az_done ||
					got.cam_busy !== due.cam_busy ||
					got.cam_position !== due.cam_position || got.last !== due.last) begin
				failures++;
				if (failures <= REPORT_MAX) begin
					$display("word mismatch");
					show("expected", due);
					show("got     ", got);
				end
			end
		endfunction

		function int outstanding();
			return words_due.size();
		endfunction

		function void close_out();
			if (words_due.size() != 0) begin
				$display("%0d words never arrived", words_due.size());
				failures += words_due.size();
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dss_req_if req_ch ();
	dss_rsp_if rsp_ch ();

	coil_scoreboard sb;

	// Shared idling controls. While calm is set neither side starts a gap; squeeze_on asks
	// the receiver for one long hold-off and keeps the sender offering back to back.
	bit calm       = 1'b0;
	bit squeeze_on = 1'b0;

	dual_stepper_half_step_slew_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic item_t cmd(logic [2:0] a, logic [15:0] t, logic [15:0] c);
		item_t w;
		w.action        = a;
		w.target_angle  = t;
		w.current_angle = c;
		return w;
	endfunction

	// Commands whose angle fields do not matter still carry random bits.
	function automatic item_t filler(logic [2:0] a);
		return cmd(a, 16'($urandom), 16'($urandom));
	endfunction

	// Azimuth requests: mostly in-range angles, often placed right around the
	// tolerance band, sometimes raw 16-bit values that need several wraps.
	function automatic item_t make_az();
		item_t c;
		int    r;
		int    off;
		int    tgt;
		r = $urandom_range(0, 9);
		c = filler(ACT_AZ_STEP);
		if (r != 0) begin
			tgt = $urandom_range(0, FULL_TURN - 1);
			c.target_angle = 16'(tgt);
			if (r < 5) begin
				off = int'($urandom_range(0, 2 * sb.tol + 4)) - int'(sb.tol) - 2;
				c.current_angle = 16'((tgt + off + FULL_TURN) % FULL_TURN);
			end else begin
				c.current_angle = 16'($urandom_range(0, FULL_TURN - 1));
			end
		end
		return c;
	endfunction

	// Camera moves are steered so that a move plays out in a handful of ticks;
	// a raw target is used only when it happens to be short as well.
	function automatic item_t make_move();
		item_t       c;
		int unsigned t;
		int unsigned delta;
		int unsigned k;
		c = filler(ACT_CAM_MOVE);
		t = $urandom_range(0, 65535);
		if ($urandom_range(0, 3) != 0 || sb.steps_for(16'(t)) > 40) begin
			k = $urandom_range(0, 10);
			if (sb.spd == 0)
				delta = $urandom_range(0, CAM_MAX);
			else
				delta = (k * Q88_HUNDREDTH + $urandom_range(0, Q88_HUNDREDTH - 1)) / sb.spd;
			if (delta > CAM_MAX)
				delta = CAM_MAX;
			if ($urandom_range(0, 1) != 0) begin
				t = sb.cam_angle + delta;
				// Past the top end the target saturates, so try oversized values too.
				if (t >= CAM_MAX)
					t = ($urandom_range(0, 1) != 0) ? $urandom_range(CAM_MAX, 65535) : CAM_MAX;
			end else begin
				t = (delta > sb.cam_angle) ? 0 : sb.cam_angle - delta;
			end
		end
		c.target_angle = 16'(t);
		return c;
	endfunction

	// While a move is in flight the mix leans on ticks so moves complete; when
	// idle it leans on new moves and azimuth work. A few words are noise.
	function automatic item_t pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (sb.steps_left != 0) begin
			if (r < 60) return filler(ACT_TICK);
			if (r < 78) return make_az();
			if (r < 84) return make_move();
			if (r < 90) return filler(ACT_CAM_STOP);
			if (r < 95) return filler(ACT_AZ_STOP);
		end else begin
			if (r < 35) return make_move();
			if (r < 65) return make_az();
			if (r < 75) return filler(ACT_TICK);
			if (r < 83) return filler(ACT_AZ_STOP);
			if (r < 91) return filler(ACT_CAM_STOP);
		end
		return filler(3'($urandom_range(5, 7)));
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int sender_gap();
		int r;
		if (calm || squeeze_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int receiver_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one command word and returns at the edge that accepts it. Valid is
	// only lowered when a gap is actually inserted, so back-to-back words keep it
	// high without a second assignment in the same step.
	task automatic send_command(input item_t c);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.action        <= c.action;
		req_ch.target_angle  <= c.target_angle;
		req_ch.current_angle <= c.current_angle;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.accept_command(c);
	endtask

	// Waits until every owed word has come back, then lets the core settle.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	// Both registers are written one after the other while the core is idle.
	task automatic program_regs(input logic [14:0] tol, input logic [15:0] spd);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_AZ_TOLERANCE;
		cfg_data  <= {1'b0, tol};
		@(posedge clk);
		sb.write_reg(CFG_AZ_TOLERANCE, {1'b0, tol});
		cfg_index <= CFG_CAM_SPD;
		cfg_data  <= spd;
		@(posedge clk);
		sb.write_reg(CFG_CAM_SPD, spd);
		cfg_wr_en <= 1'b0;
	endtask

	// Response side: random stalls, calm stretches, and one long hold-off on request.
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (squeeze_on) begin
				rsp_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_on = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall = receiver_gap();
			end
		end
	end

	// Every accepted response word is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			w.coil_byte    = rsp_ch.coil_byte;
			w.az_done      = rsp_ch.az_done;
			w.cam_busy     = rsp_ch.cam_busy;
			w.cam_position = rsp_ch.cam_position;
			w.last         = rsp_ch.last;
			sb.compare_word(w);
		end
	end

	// Watchdog: ends the run if neither channel moves a word for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		item_t       c;
		int          counted;
		logic [14:0] tol;
		logic [15:0] spd;

		sb = new();
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.action        = ACT_AZ_STEP;
		req_ch.target_angle  = '0;
		req_ch.current_angle = '0;
		cfg_wr_en            = 1'b0;
		cfg_index            = CFG_AZ_TOLERANCE;
		cfg_data             = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset defaults: tolerance 50, ten steps per degree.
		send_command(filler(ACT_TICK));                            // tick with camera idle
		send_command(cmd(ACT_AZ_STEP, 16'd0, 16'd0));              // exactly on target
		send_command(cmd(ACT_AZ_STEP, 16'd50, 16'd0));             // on the tolerance edge
		send_command(cmd(ACT_AZ_STEP, 16'd100, 16'd0));            // step forward
		send_command(cmd(ACT_AZ_STEP, 16'd0, 16'd100));            // step back
		send_command(cmd(ACT_AZ_STEP, 16'd35999, 16'd0));          // wraps to within tolerance
		send_command(cmd(ACT_AZ_STEP, 16'd18000, 16'd0));          // exactly half a turn ahead
		send_command(cmd(ACT_AZ_STEP, 16'd0, 16'd18000));          // exactly half a turn behind
		send_command(cmd(ACT_AZ_STEP, 16'hFFFF, 16'd0));           // out of range, wraps
		send_command(cmd(ACT_AZ_STEP, 16'd0, 16'hFFFF));           // out of range, wraps
		send_command(filler(ACT_AZ_STOP));
		send_command(cmd(ACT_CAM_MOVE, 16'd30, 16'hFFFF));         // three-step move up
		send_command(cmd(ACT_CAM_MOVE, 16'd10000, 16'd0));         // ignored while busy
		send_command(filler(ACT_CAM_STOP));                        // coils off, steps remain
		repeat (3) send_command(filler(ACT_TICK));                 // last tick owes two words
		send_command(cmd(ACT_CAM_MOVE, 16'd30, 16'hFFFF));         // zero-step move
		send_command(cmd(ACT_CAM_MOVE, 16'd0, 16'd0));             // three-step move down
		send_command(cmd(ACT_AZ_STEP, 16'd200, 16'd0));            // azimuth step re-energizes camera
		repeat (3) send_command(filler(ACT_TICK));
		send_command(cmd(3'd7, 16'hFFFF, 16'hFFFF));               // unknown action
		send_command(filler(ACT_CAM_STOP));

		// Random phases, each with its own register setting, extremes included.
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin tol = 15'd0;     spd = 16'hFFFF; end
				1: begin tol = CAM_MAX;   spd = 16'd0;    end
				2: begin tol = AZ_TOL_RST; spd = CAM_SPD_RST; end
				3: begin tol = 15'($urandom_range(0, CAM_MAX)); spd = 16'd16; end
				4: begin tol = 15'($urandom_range(0, CAM_MAX)); spd = 16'($urandom); end
				default: begin tol = 15'd1; spd = 16'd256; end
			endcase
			program_regs(tol, spd);
			counted = 0;
			while (counted < PER_PHASE) begin
				if (counted % 40 == 0)
					calm = ($urandom_range(0, 4) == 0);
				// Once per run the receiver holds off long enough to back the core up.
				if (p == 2 && counted == 100)
					squeeze_on = 1'b1;
				c = pick_command();
				send_command(c);
				if (c.action <= ACT_TICK)
					counted++;
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
